[rtl/core/ffha_pkg.sv]
// Shared constants and request codes for the first-fit heap allocator.
package ffha_pkg;

  localparam int HEAP_GRANULES_DEF   = 1024;
  localparam int HEADER_GRANULES_DEF = 3;
  localparam int GRANULE_SHIFT       = 3;

  localparam int KIND_W = 2;
  localparam int REQ_W  = 14;
  localparam int ADDR_W = 10;
  localparam int GRAN_W = REQ_W - GRANULE_SHIFT + 1;

  localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REINIT = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

endpackage

[rtl/core/first_fit_heap_allocator.sv]
// Top level of the first-fit heap allocator with free-block coalescing.
//
// Requests enter on a valid/ready channel (kind_i, request_bytes_i,
// block_address_i); every request returns exactly one result on a second
// valid/ready channel (granted_o, user_address_o). One request is in work
// at a time. Headers live in two RAMs: one holds {next link, used flag},
// the other the prev link; both have registered read data.
// Allocate walks the header list, reading one header per visit, then writes
// the split header if the block is split, marks the block used and hands
// over the result. Free walks the headers up to the freed block, merges it
// by read-modify-write with a free next block and a free previous block,
// and hands over the result. Reinitialize and rejected requests go
// straight to the result.
// The walk is bounded by one visit per heap granule.
// After reset the block writes the top header, with
// in_ready_o low, then accepts requests. A result waits in the output
// register while the receiver stalls; a finished request holds there until
// that register is free, and no new request is taken meanwhile.
module first_fit_heap_allocator
  import ffha_pkg::*;
#(
  parameter int HEAP_GRANULES   = HEAP_GRANULES_DEF,
  parameter int HEADER_GRANULES = HEADER_GRANULES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [REQ_W-1:0]  request_bytes_i,
  input  logic [ADDR_W-1:0] block_address_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              granted_o,
  output logic [ADDR_W-1:0] user_address_o
);

  localparam int AW = $clog2(HEAP_GRANULES);
  localparam int MW = ((AW > GRAN_W) ? AW : GRAN_W) + 2;
  localparam int GW = AW + 1;
  localparam logic [AW-1:0] END_HDR = AW'(HEAP_GRANULES - HEADER_GRANULES);
  localparam logic [MW-1:0] HDR_M   = MW'(HEADER_GRANULES);
  localparam logic [MW-1:0] END_M   = MW'(HEAP_GRANULES - HEADER_GRANULES);
  localparam logic [GW-1:0] HEAP_G  = GW'(HEAP_GRANULES);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_WALK, S_CHK, S_SPLIT, S_MARK,
    S_FWALK, S_FCHK, S_FRH, S_FRN, S_FRP, S_RESP
  } state_e;

  state_e st_q, st_d;
  logic [AW-1:0] cur_q, cur_d, h_q, h_d, nx_q, nx_d, nh_q, nh_d, p_q, p_d;
  logic [GW-1:0] guard_q, guard_d;
  logic [GRAN_W-1:0] g_q, g_d;
  logic split_q, split_d, ok_q, ok_d;
  logic [AW-1:0] addr_q, addr_d;
  logic out_valid_q, out_valid_d, granted_q, granted_d;
  logic [ADDR_W-1:0] uaddr_q, uaddr_d;

  logic a_we, a_re, b_we, b_re;
  logic [AW-1:0] a_waddr, a_raddr, b_waddr, b_raddr;
  logic [AW:0] a_wdata, a_rdata;
  logic [AW-1:0] b_wdata, b_rdata;

  logic [AW-1:0] rd_next;
  logic rd_used;
  logic [MW-1:0] span, need, baddr_m, hdr_m;

  ffha_ram #(.WIDTH(AW + 1), .DEPTH(HEAP_GRANULES)) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (a_we),
    .waddr_i(a_waddr),
    .wdata_i(a_wdata),
    .re_i   (a_re),
    .raddr_i(a_raddr),
    .rdata_o(a_rdata)
  );

  ffha_ram #(.WIDTH(AW), .DEPTH(HEAP_GRANULES)) u_prev_ram (
    .clk_i  (clk_i),
    .we_i   (b_we),
    .waddr_i(b_waddr),
    .wdata_i(b_wdata),
    .re_i   (b_re),
    .raddr_i(b_raddr),
    .rdata_o(b_rdata)
  );

  assign rd_next = a_rdata[AW:1];
  assign rd_used = a_rdata[0];
  assign span    = MW'(rd_next) - MW'(cur_q);
  assign need    = MW'(g_q) + HDR_M;
  assign baddr_m = MW'(block_address_i);
  assign hdr_m   = baddr_m - HDR_M;

  always_comb begin
    st_d        = st_q;
    cur_d       = cur_q;
    h_d         = h_q;
    nx_d        = nx_q;
    nh_d        = nh_q;
    p_d         = p_q;
    guard_d     = guard_q;
    g_d         = g_q;
    split_d     = split_q;
    ok_d        = ok_q;
    addr_d      = addr_q;
    granted_d   = granted_q;
    uaddr_d     = uaddr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    a_we = 1'b0; a_waddr = '0; a_wdata = '0; a_re = 1'b0; a_raddr = '0;
    b_we = 1'b0; b_waddr = '0; b_wdata = '0; b_re = 1'b0; b_raddr = '0;
    unique case (st_q)
      S_INIT: begin
        a_we    = 1'b1;
        a_waddr = '0;
        a_wdata = {END_HDR, 1'b0};
        st_d    = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          g_d     = GRAN_W'(((REQ_W + 1)'(request_bytes_i) + (REQ_W + 1)'(7))
                            >> GRANULE_SHIFT);
          h_d     = AW'(hdr_m);
          cur_d   = '0;
          guard_d = '0;
          ok_d    = 1'b0;
          addr_d  = '0;
          st_d    = S_RESP;
          unique case (kind_i)
            KIND_ALLOC: begin
              if (request_bytes_i != '0) st_d = S_WALK;
            end
            KIND_FREE: begin
              if (baddr_m >= HDR_M && hdr_m < END_M) st_d = S_FWALK;
            end
            KIND_REINIT: begin
              a_we    = 1'b1;
              a_waddr = '0;
              a_wdata = {END_HDR, 1'b0};
              ok_d    = 1'b1;
            end
            default: ok_d = 1'b0;
          endcase
        end
      end
      S_WALK: begin
        if (cur_q < END_HDR && guard_q < HEAP_G) begin
          a_re    = 1'b1;
          a_raddr = cur_q;
          st_d    = S_CHK;
        end else begin
          st_d = S_RESP;
        end
      end
      S_CHK: begin
        if (!rd_used && rd_next > cur_q && span >= need) begin
          nx_d    = rd_next;
          split_d = (span >= need + HDR_M);
          nh_d    = (span >= need + HDR_M) ? AW'(MW'(cur_q) + need) : rd_next;
          st_d    = (span >= need + HDR_M) ? S_SPLIT : S_MARK;
        end else begin
          cur_d   = rd_next;
          guard_d = guard_q + GW'(1);
          st_d    = S_WALK;
        end
      end
      S_SPLIT: begin
        a_we    = 1'b1;
        a_waddr = nh_q;
        a_wdata = {nx_q, 1'b0};
        b_we    = 1'b1;
        b_waddr = nh_q;
        b_wdata = cur_q;
        st_d    = S_MARK;
      end
      S_MARK: begin
        a_we    = 1'b1;
        a_waddr = cur_q;
        a_wdata = {nh_q, 1'b1};
        b_we    = split_q;
        b_waddr = nx_q;
        b_wdata = nh_q;
        ok_d    = 1'b1;
        addr_d  = AW'(MW'(cur_q) + HDR_M);
        st_d    = S_RESP;
      end
      S_FWALK: begin
        if (cur_q < END_HDR && guard_q < HEAP_G) begin
          a_re    = 1'b1;
          a_raddr = cur_q;
          if (cur_q == h_q) begin
            b_re    = 1'b1;
            b_raddr = h_q;
            st_d    = S_FRH;
          end else begin
            st_d = S_FCHK;
          end
        end else begin
          st_d = S_RESP;
        end
      end
      S_FCHK: begin
        cur_d   = rd_next;
        guard_d = guard_q + GW'(1);
        st_d    = S_FWALK;
      end
      S_FRH: begin
        nx_d    = rd_next;
        p_d     = b_rdata;
        a_we    = 1'b1;
        a_waddr = h_q;
        a_wdata = {rd_next, 1'b0};
        a_re    = 1'b1;
        a_raddr = rd_next;
        st_d    = S_FRN;
      end
      S_FRN: begin
        if (nx_q != END_HDR && !rd_used) begin
          nx_d    = rd_next;
          a_we    = 1'b1;
          a_waddr = h_q;
          a_wdata = {rd_next, 1'b0};
          b_we    = 1'b1;
          b_waddr = rd_next;
          b_wdata = h_q;
        end
        ok_d = 1'b1;
        if (h_q != '0) begin
          a_re    = 1'b1;
          a_raddr = p_q;
          st_d    = S_FRP;
        end else begin
          st_d = S_RESP;
        end
      end
      S_FRP: begin
        if (!rd_used) begin
          a_we    = 1'b1;
          a_waddr = p_q;
          a_wdata = {nx_q, 1'b0};
          b_we    = 1'b1;
          b_waddr = nx_q;
          b_wdata = p_q;
        end
        st_d = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          granted_d   = ok_q;
          uaddr_d     = ADDR_W'(addr_q);
          st_d        = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    h_q       <= h_d;
    nx_q      <= nx_d;
    nh_q      <= nh_d;
    p_q       <= p_d;
    guard_q   <= guard_d;
    g_q       <= g_d;
    split_q   <= split_d;
    ok_q      <= ok_d;
    addr_q    <= addr_d;
    granted_q <= granted_d;
    uaddr_q   <= uaddr_d;
  end

  assign in_ready_o     = (st_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign granted_o      = granted_q;
  assign user_address_o = uaddr_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while a request is in work");

  a_fail_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !granted_o |-> user_address_o == '0)
    else $error("failed request carries a nonzero address");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(granted_o) && $stable(user_address_o))
    else $error("stalled result dropped or changed");

endmodule

[rtl/core/ffha_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
